// ----- hw/rtl/csort_pkg.sv -----
// Shared constants, types and the compare function of the cocktail shaker sorter.
`default_nettype none

package csort_pkg;

  // Store geometry
  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Register port: byte address bit 2 selects the register word
  localparam int   PADDR_W              = 3;
  localparam logic REG_DESCENDING_ORDER = 1'b0;

  // Sequencer phase, seen by the top level
  typedef struct packed {
    logic loading;
    logic sorting;
    logic emitting;
  } seq_status_t;

  // True when the left value must move right of the right value
  function automatic logic out_of_order(input logic              desc,
                                        input logic [DATA_W-1:0] left,
                                        input logic [DATA_W-1:0] right);
    logic lt;
    logic gt;
    lt = $signed(left) < $signed(right);
    gt = $signed(left) > $signed(right);
    return desc ? lt : gt;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/csort_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module csort_ram #(
  parameter int WIDTH     = 32,
  parameter int NUM_WORDS = 64
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(NUM_WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic [$clog2(NUM_WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [NUM_WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csort_seq.sv -----
// Load, sort and unload sequencer; a sort pass walks the store one entry a cycle.
`default_nettype none

module csort_seq
  import csort_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              descending_order,
  input  logic [DATA_W-1:0] value,
  input  logic              final_item,
  input  logic              in_valid,
  output logic              in_ready,
  output logic [DATA_W-1:0] sorted_value,
  output logic              end_of_set,
  output logic              overflow,
  output logic              out_valid,
  input  logic              out_ready,
  output seq_status_t       status
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_OREAD = 3'd5;
  localparam logic [2:0] S_OLOAD = 3'd6;
  localparam logic [2:0] S_OWAIT = 3'd7;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  set_size;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] out_idx;
  logic [DATA_W-1:0] carry;
  logic              backward;
  logic              swap_seen;
  logic              dropped;
  logic              desc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              in_beat;
  logic              has_room;
  logic              swap;
  logic              pass_end;
  logic              out_last;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] second_last;

  csort_ram #(
    .WIDTH     (DATA_W),
    .NUM_WORDS (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready    = (state == S_LOAD);
  assign in_beat     = in_valid && in_ready;
  assign has_room    = (count < CNT_W'(DEPTH));
  assign count_next  = has_room ? count + CNT_W'(1) : count;
  assign last_addr   = ADDR_W'(set_size - CNT_W'(1));
  assign second_last = ADDR_W'(set_size - CNT_W'(2));
  assign out_last    = ((CNT_W'(out_idx) + CNT_W'(1)) == set_size);

  // Compare the carried element with the one just read
  assign swap     = backward ? out_of_order(desc, ram_rdata, carry)
                             : out_of_order(desc, carry, ram_rdata);
  assign pass_end = backward ? (idx == '0)
                             : ((CNT_W'(idx) + CNT_W'(1)) == set_size);

  // Drive the store ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = carry;
    ram_raddr = idx;
    unique case (state)
      S_LOAD: begin
        ram_we    = in_beat && has_room;
        ram_waddr = ADDR_W'(count);
        ram_wdata = value;
      end
      S_PRIME: begin
        ram_raddr = '0;
      end
      S_FIRST: begin
        ram_raddr = ADDR_W'(1);
      end
      S_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = backward ? idx + ADDR_W'(1) : idx - ADDR_W'(1);
        ram_wdata = swap ? ram_rdata : carry;
        ram_raddr = backward ? idx - ADDR_W'(1) : idx + ADDR_W'(1);
      end
      S_FLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = backward ? '0 : last_addr;
        ram_wdata = carry;
        ram_raddr = backward ? ADDR_W'(1) : second_last;
      end
      S_OREAD, S_OLOAD, S_OWAIT: begin
        ram_raddr = out_idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      set_size  <= '0;
      idx       <= '0;
      out_idx   <= '0;
      backward  <= 1'b0;
      swap_seen <= 1'b0;
      dropped   <= 1'b0;
      desc      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            count <= count_next;
            if (!has_room) begin
              dropped <= 1'b1;
            end
            if (final_item) begin
              set_size  <= count_next;
              desc      <= descending_order;
              out_idx   <= '0;
              backward  <= 1'b0;
              swap_seen <= 1'b0;
              state     <= (count_next < CNT_W'(2)) ? S_OREAD : S_PRIME;
            end
          end
        end
        S_PRIME: begin
          state <= S_FIRST;
        end
        S_FIRST: begin
          idx   <= ADDR_W'(1);
          state <= S_STEP;
        end
        S_STEP: begin
          if (swap) begin
            swap_seen <= 1'b1;
          end
          if (pass_end) begin
            state <= S_FLUSH;
          end else begin
            idx <= backward ? idx - ADDR_W'(1) : idx + ADDR_W'(1);
          end
        end
        S_FLUSH: begin
          swap_seen <= 1'b0;
          if (swap_seen) begin
            // turn around: the carried element stays as the new start
            backward <= !backward;
            idx      <= backward ? ADDR_W'(1) : second_last;
            state    <= S_STEP;
          end else begin
            backward <= 1'b0;
            out_idx  <= '0;
            state    <= S_OREAD;
          end
        end
        S_OREAD: begin
          state <= S_OLOAD;
        end
        S_OLOAD: begin
          out_valid <= 1'b1;
          state     <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              out_idx <= out_idx + ADDR_W'(1);
              state   <= S_OREAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Hold the carried element and the result beat
  always_ff @(posedge clk) begin
    if (state == S_FIRST) begin
      carry <= ram_rdata;
    end else if (state == S_STEP && !swap) begin
      carry <= ram_rdata;
    end
    if (state == S_OLOAD) begin
      sorted_value <= ram_rdata;
      end_of_set   <= out_last;
      overflow     <= dropped;
    end
  end

  assign status.loading  = (state == S_LOAD);
  assign status.sorting  = (state == S_PRIME) || (state == S_FIRST) ||
                           (state == S_STEP)  || (state == S_FLUSH);
  assign status.emitting = (state == S_OREAD) || (state == S_OLOAD) ||
                           (state == S_OWAIT);

endmodule

`default_nettype wire

// ----- hw/rtl/cocktail_shaker_sorter.sv -----
// Cocktail shaker sorter: collects a set, sorts it in a RAM and streams it out.
//
// Input channel (value, final_item; in_valid/in_ready): one beat per element.
// Each beat is written to a 64-entry store; elements beyond 64 are dropped
// and the whole set then reports overflow. A beat with final_item set
// closes the set and starts the sort. in_ready is high only while loading.
// Sort: alternating forward and backward passes, each walking the store one
// entry per cycle through one RAM read port and one write port, with the
// moving element held in a register, plus a write-back step per pass, until
// a pass makes no swap. For n elements at most n passes run, after the
// S_PRIME and S_FIRST setup states.
// Output channel (sorted_value, end_of_set, overflow; out_valid/out_ready):
// one beat per element, each read, loaded and accepted before the next read;
// end_of_set marks the last beat. A stalled receiver simply holds the beat
// and the sequencer waits. After the last beat the block loads again.
// Configuration: APB register 0, bit 0 = descending_order, sampled when the
// final item arrives. Reset (rst, synchronous) empties the set, clears the
// flags and the register; the store itself is not cleared.
`default_nettype none

module cocktail_shaker_sorter
  import csort_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     final_item,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     end_of_set,
  output logic                     overflow,
  output logic                     out_valid,
  input  logic                     out_ready
);

  logic        descending_order;
  logic        reg_hit;
  seq_status_t status;
  logic [DATA_W-1:0] sorted_bits;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_DESCENDING_ORDER);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      descending_order <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      descending_order <= pwdata[0];
    end
  end

  // Register read
  assign prdata = reg_hit ? {31'd0, descending_order} : 32'd0;

  csort_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .descending_order (descending_order),
    .value            (value),
    .final_item       (final_item),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sorted_value     (sorted_bits),
    .end_of_set       (end_of_set),
    .overflow         (overflow),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status)
  );

  assign sorted_value = $signed(sorted_bits);

  // Loading and unloading never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at the same time");

  // Nothing moves on either channel while sorting
  a_sort_quiet: assert property (@(posedge clk) disable iff (rst)
    status.sorting |-> (!in_ready && !out_valid))
    else $error("channel active during sort");

  // A closing input beat ends loading
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && final_item) |=> !in_ready)
    else $error("still loading after final item");

  // The last result beat returns the block to loading
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && end_of_set) |=> (in_ready && !out_valid))
    else $error("not loading after last result");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the cocktail shaker sorter.
`timescale 1ns / 100ps

module tb_top;
  import csort_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } sorted_beat_t;

  // One directed element; known rows carry their single-element result
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_item;
    bit                       known;
    logic signed [DATA_W-1:0] known_value;
  } stim_row_t;

  localparam logic                     REG_UNUSED   = 1'b1;
  localparam logic signed [DATA_W-1:0] VAL_MIN      = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int                       PHASES       = 5;
  localparam int                       PHASE_ITEMS  = 96;
  localparam int                       LONG_HOLD    = 600;
  localparam int                       HOLD_AT_BEAT = 40;
  localparam int                       SETTLE       = 16;
  localparam int                       NUM_ROWS     = 19;

  // Register setting and opening set size of each random phase
  localparam logic        PHASE_REG  [PHASES] = '{REG_DESCENDING_ORDER, REG_DESCENDING_ORDER,
                                                  REG_UNUSED, REG_DESCENDING_ORDER,
                                                  REG_DESCENDING_ORDER};
  localparam logic [31:0] PHASE_DATA [PHASES] = '{32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0001,
                                                  32'hFFFF_FFFF, 32'h0000_0000};
  localparam int          PHASE_OPEN [PHASES] = '{DEPTH + 2, DEPTH, DEPTH + 1, DEPTH + 6, 1};

  logic                     clk;
  logic                     rst        = 1'b1;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [PADDR_W-1:0]       paddr      = '0;
  logic [31:0]              pwdata     = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic signed [DATA_W-1:0] value      = '0;
  logic                     final_item = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_set;
  logic                     overflow;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;

  // Predictor state
  logic signed [DATA_W-1:0] model_store [DEPTH];
  int                       model_count      = 0;
  logic                     model_dropped    = 1'b0;
  logic                     model_descending = 1'b0;

  sorted_beat_t expected_beats [$];
  int           error_count = 0;

  // Directed sets: single-element extremes, a mixed set with duplicates,
  // an already sorted set, a reversed set and an equal pair
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{VAL_MIN,     1'b1, 1'b1, VAL_MIN},
    '{VAL_MAX,     1'b1, 1'b1, VAL_MAX},
    '{32'sd0,      1'b1, 1'b1, 32'sd0},
    '{-32'sd1,     1'b1, 1'b1, -32'sd1},
    '{VAL_MAX,     1'b0, 1'b0, 32'sd0},
    '{VAL_MIN,     1'b0, 1'b0, 32'sd0},
    '{32'sd5,      1'b0, 1'b0, 32'sd0},
    '{-32'sd1,     1'b0, 1'b0, 32'sd0},
    '{32'sd5,      1'b0, 1'b0, 32'sd0},
    '{32'sd0,      1'b0, 1'b0, 32'sd0},
    '{32'sd1,      1'b1, 1'b0, 32'sd0},
    '{32'sd1,      1'b0, 1'b0, 32'sd0},
    '{32'sd2,      1'b0, 1'b0, 32'sd0},
    '{32'sd3,      1'b1, 1'b0, 32'sd0},
    '{32'sd3,      1'b0, 1'b0, 32'sd0},
    '{32'sd2,      1'b0, 1'b0, 32'sd0},
    '{32'sd1,      1'b1, 1'b0, 32'sd0},
    '{32'sd7,      1'b0, 1'b0, 32'sd0},
    '{32'sd7,      1'b1, 1'b0, 32'sd0}
  };

  cocktail_shaker_sorter dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .value        (value),
    .final_item   (final_item),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .overflow     (overflow),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // True when a pair sits in the wrong order for the current setting
  function automatic bit misplaced(input logic signed [DATA_W-1:0] left,
                                   input logic signed [DATA_W-1:0] right);
    return model_descending ? (left < right) : (left > right);
  endfunction

  // Store one accepted element; on the final one sort the held set and queue its beats
  task automatic absorb_element(input logic signed [DATA_W-1:0] v, input logic fin,
                                input bit queue_beats);
    int                       lo;
    int                       hi;
    int                       i;
    bit                       swapped;
    logic signed [DATA_W-1:0] t;
    sorted_beat_t             b;
    if (model_count < DEPTH) begin
      model_store[model_count] = v;
      model_count++;
    end else begin
      model_dropped = 1'b1;
    end
    if (fin) begin
      lo = 0;
      hi = model_count - 1;
      swapped = 1'b1;
      // Shake forward then backward, narrowing the window each way
      while (swapped && lo < hi) begin
        swapped = 1'b0;
        for (i = lo; i < hi; i++) begin
          if (misplaced(model_store[i], model_store[i+1])) begin
            t = model_store[i];
            model_store[i] = model_store[i+1];
            model_store[i+1] = t;
            swapped = 1'b1;
          end
        end
        hi--;
        for (i = hi; i > lo; i--) begin
          if (misplaced(model_store[i-1], model_store[i])) begin
            t = model_store[i];
            model_store[i] = model_store[i-1];
            model_store[i-1] = t;
            swapped = 1'b1;
          end
        end
        lo++;
      end
      if (queue_beats) begin
        for (i = 0; i < model_count; i++) begin
          b.sorted_value = model_store[i];
          b.end_of_set   = (i == model_count - 1);
          b.overflow     = model_dropped;
          expected_beats.push_back(b);
        end
      end
      model_count   = 0;
      model_dropped = 1'b0;
    end
  endtask

  // Mostly back to back, sometimes short pauses, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Favor extremes and a narrow band so that duplicates are common
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sets, a few full and a few overfull
  function automatic int pick_set_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 30);
    if (r < 92) return DEPTH;
    return $urandom_range(DEPTH + 1, DEPTH + 4);
  endfunction

  // Offer one element and hold it until the block takes it
  task automatic offer_element(input logic signed [DATA_W-1:0] v, input logic fin,
                               input int gap, input bit queue_beats);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value      <= v;
    final_item <= fin;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_element(v, fin, queue_beats);
  endtask

  task automatic send_set(input int len);
    int k;
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++)
      offer_element(pick_value(), k == len - 1, calm ? 0 : pick_gap(), 1'b1);
  endtask

  // Drop valid, wait for every queued beat, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Read back the order register and compare with the predictor
  task automatic check_register();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_DESCENDING_ORDER, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, model_descending}) begin
      $display("%0t: descending_order readback expected %0h got %0h",
               $time, {31'b0, model_descending}, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_DESCENDING_ORDER) model_descending = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_register();
  endtask

  // Compare one output beat with the oldest expectation
  task automatic check_beat();
    sorted_beat_t want;
    if (expected_beats.size() == 0) begin
      error_count++;
      $display("%0t: beat with nothing expected: sorted_value %0d end_of_set %0b overflow %0b",
               $time, sorted_value, end_of_set, overflow);
    end else begin
      want = expected_beats.pop_front();
      if (sorted_value !== want.sorted_value) begin
        error_count++;
        $display("%0t: sorted_value expected %0d got %0d",
                 $time, want.sorted_value, sorted_value);
      end
      if (end_of_set !== want.end_of_set) begin
        error_count++;
        $display("%0t: end_of_set expected %0b got %0b", $time, want.end_of_set, end_of_set);
      end
      if (overflow !== want.overflow) begin
        error_count++;
        $display("%0t: overflow expected %0b got %0b", $time, want.overflow, overflow);
      end
    end
  endtask

  // Receiver: check accepted beats and vary out_ready, with one long hold-off
  initial begin : receiver
    int stall_left;
    int calm_left;
    int beats_seen;
    bit held_long;
    stall_left = 0;
    calm_left  = 0;
    beats_seen = 0;
    held_long  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        check_beat();
        beats_seen++;
      end
      if (!held_long && beats_seen == HOLD_AT_BEAT) begin
        held_long  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 150);
        else stall_left = pick_gap();
      end
    end
  end

  // Sender: reset, directed table, then random phases under different settings
  initial begin : sender
    int        p;
    int        n;
    int        len;
    int        row;
    stim_row_t r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    check_register();

    // Directed part runs with the reset order
    for (row = 0; row < NUM_ROWS; row++) begin
      r = directed_rows[row];
      offer_element(r.value, r.final_item, pick_gap(), !r.known);
      if (r.known) expected_beats.push_back(sorted_beat_t'{r.known_value, 1'b1, 1'b0});
    end

    // Random part: reconfigure only once the block has gone quiet
    for (p = 0; p < PHASES; p++) begin
      drain();
      write_register(PHASE_REG[p], (p == PHASES - 1) ? $urandom : PHASE_DATA[p]);
      send_set(PHASE_OPEN[p]);
      n = PHASE_OPEN[p];
      while (n < PHASE_ITEMS) begin
        len = pick_set_len();
        send_set(len);
        n += len;
      end
    end
    drain();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
